// ===== src/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants for the first-fit block allocator
// Block table geometry, request/result payloads, status codes, config
// register indexes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // table geometry
  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 16;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

  // field widths
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 21;
  localparam int ALIGN_W    = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // break plus header, padded data start and data end without wrap
  localparam int DIVD_W = ADDR_W + 1;
  localparam int DATA_W = ADDR_W + 2;
  localparam int END_W  = ADDR_W + 3;

  // register defaults
  localparam logic [ALIGN_W-1:0] ALIGN_RST     = ALIGN_W'(16);
  localparam logic [ADDR_W-1:0]  HEAP_BASE_RST = '0;
  localparam logic [ADDR_W-1:0]  HEAP_LIMIT_RST = '1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGNMENT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = CFG_IDX_W'(2);

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_REUSED   = 3'd0,
    ST_NEW      = 3'd1,
    ST_RELEASED = 3'd2,
    ST_MARKED   = 3'd3,
    ST_OOM      = 3'd4,
    ST_IGNORED  = 3'd5
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [SIZE_W-1:0]  request_size;
    logic [ADDR_W-1:0]  free_address;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] data_address;
    status_t           status;
  } out_t;

  // one row of the block table
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              is_free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MOD,
    S_PAD,
    S_PLACE,
    S_CHECK,
    S_DONE
  } state_t;

endpackage

// ===== src/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ffa_rem.sv =====
// ----------------------------------------------------------------------------
// ffa_rem: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; returns only the remainder.
// Divisor must stay stable while the unit runs.
// ----------------------------------------------------------------------------
module ffa_rem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ffa_pkg::DIVD_W-1:0]  dividend,
  input  logic [ffa_pkg::ALIGN_W-1:0] divisor,
  output logic                        done,
  output logic [ffa_pkg::ALIGN_W-1:0] remainder
);

  localparam int STEP_W = $clog2(ffa_pkg::DIVD_W + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [ffa_pkg::DIVD_W-1:0]  divd_r, divd_nxt;
  logic [ffa_pkg::ALIGN_W-1:0] rem_r, rem_nxt;
  logic [ffa_pkg::ALIGN_W:0]   trial;

  // one shift-subtract step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    divd_nxt = divd_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, divd_r[ffa_pkg::DIVD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(ffa_pkg::DIVD_W);
      divd_nxt = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = ffa_pkg::ALIGN_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[ffa_pkg::ALIGN_W-1:0];
      end
      divd_nxt = {divd_r[ffa_pkg::DIVD_W-2:0], 1'b0};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    divd_r <= divd_nxt;
    rem_r  <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== src/first_fit_aligned_block_allocator_top.sv =====
// A request walks the block table at one entry per cycle; a new block then
// also runs the bit-serial remainder unit, followed by padding and the limit
// check. Only one request is handled at a time.
// Reset (synchronous, rst_n low): empty table, break at the heap base default,
// config registers at their defaults; no table clearing pass is needed.
// ----------------------------------------------------------------------------
// first_fit_aligned_block_allocator_top: first-fit heap block allocator
// Sequencer over a block table RAM, a break pointer and a remainder
// unit used for alignment padding of new blocks.
// ----------------------------------------------------------------------------
module first_fit_aligned_block_allocator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ffa_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ffa_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ffa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffa_pkg::CFG_DATA_W-1:0] cfg_data
);

  ffa_pkg::state_t             state_r, state_nxt;
  ffa_pkg::in_t                req_r, req_nxt;
  ffa_pkg::out_t               res_r, res_nxt;
  ffa_pkg::out_t               out_data_r, out_data_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ffa_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic                        pend_r, pend_nxt;
  logic [ffa_pkg::IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [ffa_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [ffa_pkg::ADDR_W-1:0]  break_r, break_nxt;
  logic [ffa_pkg::DIVD_W-1:0]  after_hdr_r, after_hdr_nxt;
  logic [ffa_pkg::ALIGN_W-1:0] pad_r, pad_nxt;
  logic [ffa_pkg::DATA_W-1:0]  data_r, data_nxt;
  logic [ffa_pkg::ALIGN_W-1:0] align_r;
  logic [ffa_pkg::ADDR_W-1:0]  limit_r;

  logic [ffa_pkg::ALIGN_W-1:0] align_eff;
  logic [ffa_pkg::DIVD_W-1:0]  after_hdr;
  logic [ffa_pkg::END_W-1:0]   end_sum;
  ffa_pkg::entry_t             rd;
  logic                        match;

  logic                        ram_we;
  logic [ffa_pkg::IDX_W-1:0]   ram_waddr;
  ffa_pkg::entry_t             ram_wdata;
  logic [ffa_pkg::ENTRY_W-1:0] ram_rdata;

  logic                        rem_start;
  logic                        rem_done;
  logic [ffa_pkg::ALIGN_W-1:0] rem_value;

  // block table
  ffa_ram #(
    .WIDTH (ffa_pkg::ENTRY_W),
    .DEPTH (ffa_pkg::MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[ffa_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // alignment remainder of break plus header
  ffa_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (after_hdr),
    .divisor   (align_eff),
    .done      (rem_done),
    .remainder (rem_value)
  );

  // zero alignment behaves as one
  assign align_eff = (align_r == '0) ? ffa_pkg::ALIGN_W'(1) : align_r;
  assign after_hdr = {1'b0, break_r} + ffa_pkg::DIVD_W'(ffa_pkg::HEADER_BYTES);
  assign end_sum   = ffa_pkg::END_W'(data_r) + ffa_pkg::END_W'(req_r.request_size);
  assign rd        = ffa_pkg::entry_t'(ram_rdata);

  // entry match for the request in flight
  always_comb begin
    if (req_r.kind == ffa_pkg::KIND_ALLOC) begin
      match = rd.is_free && (rd.size >= req_r.request_size);
    end else begin
      match = (rd.start == req_r.free_address);
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    hit_idx_nxt   = hit_idx_r;
    count_nxt     = count_r;
    break_nxt     = break_r;
    after_hdr_nxt = after_hdr_r;
    pad_nxt       = pad_r;
    data_nxt      = data_r;
    ram_we        = 1'b0;
    ram_waddr     = hit_idx_r;
    ram_wdata     = rd;
    rem_start     = 1'b0;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ffa_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_data;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          if (in_data.kind == ffa_pkg::KIND_FREE && in_data.free_address == '0) begin
            res_nxt   = '{data_address: '0, status: ffa_pkg::ST_IGNORED};
            state_nxt = ffa_pkg::S_DONE;
          end else begin
            state_nxt = ffa_pkg::S_SEARCH;
          end
        end
      end

      // pipelined walk: issue one read per cycle, test the previous one
      ffa_pkg::S_SEARCH: begin
        if (pend_r && match) begin
          pend_nxt  = 1'b0;
          state_nxt = ffa_pkg::S_DONE;
          if (req_r.kind == ffa_pkg::KIND_ALLOC) begin
            ram_we    = 1'b1;
            ram_wdata = '{start: rd.start, size: rd.size, is_free: 1'b0};
            res_nxt   = '{data_address: rd.start, status: ffa_pkg::ST_REUSED};
          end else if (ffa_pkg::CNT_W'(hit_idx_r) == count_r - ffa_pkg::CNT_W'(1) &&
                       rd.start + ffa_pkg::ADDR_W'(rd.size) == break_r) begin
            break_nxt = rd.start - ffa_pkg::ADDR_W'(ffa_pkg::HEADER_BYTES);
            count_nxt = count_r - ffa_pkg::CNT_W'(1);
            res_nxt   = '{data_address: '0, status: ffa_pkg::ST_RELEASED};
          end else begin
            ram_we    = 1'b1;
            ram_wdata = '{start: rd.start, size: rd.size, is_free: 1'b1};
            res_nxt   = '{data_address: '0, status: ffa_pkg::ST_MARKED};
          end
        end else if (idx_r < count_r) begin
          pend_nxt    = 1'b1;
          hit_idx_nxt = idx_r[ffa_pkg::IDX_W-1:0];
          idx_nxt     = idx_r + ffa_pkg::CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (req_r.kind == ffa_pkg::KIND_FREE) begin
            res_nxt   = '{data_address: '0, status: ffa_pkg::ST_IGNORED};
            state_nxt = ffa_pkg::S_DONE;
          end else if (count_r >= ffa_pkg::CNT_W'(ffa_pkg::MAX_BLOCKS)) begin
            res_nxt   = '{data_address: '0, status: ffa_pkg::ST_OOM};
            state_nxt = ffa_pkg::S_DONE;
          end else begin
            after_hdr_nxt = after_hdr;
            rem_start     = 1'b1;
            state_nxt     = ffa_pkg::S_MOD;
          end
        end
      end

      // wait for the remainder unit
      ffa_pkg::S_MOD: begin
        if (rem_done) begin
          state_nxt = ffa_pkg::S_PAD;
        end
      end

      ffa_pkg::S_PAD: begin
        pad_nxt   = (rem_value != '0) ? align_eff - rem_value : '0;
        state_nxt = ffa_pkg::S_PLACE;
      end

      ffa_pkg::S_PLACE: begin
        data_nxt  = ffa_pkg::DATA_W'(after_hdr_r) + ffa_pkg::DATA_W'(pad_r);
        state_nxt = ffa_pkg::S_CHECK;
      end

      // limit check and append
      ffa_pkg::S_CHECK: begin
        state_nxt = ffa_pkg::S_DONE;
        if (end_sum > ffa_pkg::END_W'(limit_r)) begin
          res_nxt = '{data_address: '0, status: ffa_pkg::ST_OOM};
        end else begin
          ram_we    = 1'b1;
          ram_waddr = count_r[ffa_pkg::IDX_W-1:0];
          ram_wdata = '{start: data_r[ffa_pkg::ADDR_W-1:0], size: req_r.request_size,
                        is_free: 1'b0};
          count_nxt = count_r + ffa_pkg::CNT_W'(1);
          break_nxt = end_sum[ffa_pkg::ADDR_W-1:0];
          res_nxt   = '{data_address: data_r[ffa_pkg::ADDR_W-1:0],
                        status: ffa_pkg::ST_NEW};
        end
      end

      // hand the result to the output register once it is free
      ffa_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ffa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ffa_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      count_r     <= '0;
      break_r     <= ffa_pkg::HEAP_BASE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      break_r     <= break_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
    idx_r       <= idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    after_hdr_r <= after_hdr_nxt;
    pad_r       <= pad_nxt;
    data_r      <= data_nxt;
  end

  // config registers; the heap base default only seeds the break at reset,
  // and a write to the heap base index has no effect
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= ffa_pkg::ALIGN_RST;
      limit_r <= ffa_pkg::HEAP_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ffa_pkg::CFG_ALIGNMENT:  align_r <= cfg_data[ffa_pkg::ALIGN_W-1:0];
        ffa_pkg::CFG_HEAP_BASE:  align_r <= align_r;
        ffa_pkg::CFG_HEAP_LIMIT: limit_r <= cfg_data;
        default:                 limit_r <= limit_r;
      endcase
    end
  end

  assign in_stall  = (state_r != ffa_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ffa_pkg::CNT_W'(ffa_pkg::MAX_BLOCKS))
    else $error("block count beyond table depth");

  // only a reuse or a new block carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ffa_pkg::ST_REUSED &&
     out_data_r.status != ffa_pkg::ST_NEW) |-> (out_data_r.data_address == '0))
    else $error("non-allocation result with nonzero address");

  // table writes only come from a search hit or an append
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ffa_pkg::S_SEARCH || state_r == ffa_pkg::S_CHECK))
    else $error("table written outside search or append");

  // count moves by at most one per request step
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |->
      (count_r == $past(count_r) + ffa_pkg::CNT_W'(1) ||
       count_r == $past(count_r) - ffa_pkg::CNT_W'(1)))
    else $error("block count jumped");

endmodule
